FILE: rtl/midpoint_semicircle_rasterizer_top_assert.svh
// Assertion helpers for the rasterizer modules; msr_fifo includes them.
`ifndef MIDPOINT_SEMICIRCLE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_SEMICIRCLE_RASTERIZER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define MSR_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// Consequence that must hold in the same cycle as the antecedent.
`define MSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Consequence that must hold in the cycle after the antecedent.
`define MSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check violated");

`endif

FILE: rtl/msr_pkg.sv
package msr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int RAD_W          = 9;
    localparam int OFF_W          = 9;
    localparam int DEC_W          = 12;
    localparam int PIX_W          = 12;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PH_W           = 2;

    localparam logic            MODE_START = 1'b0;
    localparam logic            MODE_STEP  = 1'b1;
    localparam logic [PH_W-1:0] PH_FIRST   = 2'd0;
    localparam logic [PH_W-1:0] PH_LAST    = 2'd3;

    // One queued arc position: center already folded to pixel width.
    typedef struct packed {
        logic [PIX_W-1:0] cx;
        logic [PIX_W-1:0] cy;
        logic [OFF_W-1:0] x;
        logic [OFF_W-1:0] y;
        logic             left;
        logic             done;
    } job_t;

endpackage

FILE: rtl/msr_cmd_if.sv
interface msr_cmd_if
    import msr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [RAD_W-1:0]      radius;
    logic                  left_half;

    modport source (
        output valid, mode, center_x, center_y, radius, left_half,
        input  ready
    );

    modport sink (
        input  valid, mode, center_x, center_y, radius, left_half,
        output ready
    );

endinterface

FILE: rtl/msr_pix_if.sv
interface msr_pix_if
    import msr_pkg::*;
();

    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last;
    logic                    arc_done;

    modport source (
        output valid, pixel_x, pixel_y, last, arc_done,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, last, arc_done,
        output ready
    );

endinterface

FILE: rtl/msr_front.sv
module msr_front
    import msr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    msr_cmd_if.sink  cmd,
    input  logic     q_full,
    output logic     push,
    output job_t     push_job
);

    logic [COORD_BITS-1:0] ctr_x_reg, ctr_x_next;
    logic [COORD_BITS-1:0] ctr_y_reg, ctr_y_next;
    logic                  use_left_reg, use_left_next;
    logic [OFF_W-1:0]      off_x_reg, off_x_next;
    logic [OFF_W-1:0]      off_y_reg, off_y_next;
    logic [DEC_W-1:0]      decision_reg, decision_next;

    logic             accept;
    logic             arc_end;
    logic [OFF_W-1:0] x_inc;
    logic [OFF_W-1:0] y_dec;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign arc_end   = off_x_reg >= off_y_reg;
    assign x_inc     = off_x_reg + OFF_W'(1);
    assign y_dec     = off_y_reg - OFF_W'(1);

    always_comb
    begin
        ctr_x_next    = ctr_x_reg;
        ctr_y_next    = ctr_y_reg;
        use_left_next = use_left_reg;
        off_x_next    = off_x_reg;
        off_y_next    = off_y_reg;
        decision_next = decision_reg;
        push          = 1'b0;
        if (accept)
        begin
            if (cmd.mode == MODE_START)
            begin
                ctr_x_next    = cmd.center_x;
                ctr_y_next    = cmd.center_y;
                use_left_next = cmd.left_half;
                off_x_next    = '0;
                off_y_next    = OFF_W'(cmd.radius);
                decision_next = DEC_W'(1) - DEC_W'(cmd.radius);
                push          = 1'b1;
            end
            else if (!arc_end)
            begin
                off_x_next = x_inc;
                push       = 1'b1;
                if (decision_reg[DEC_W-1])
                begin
                    decision_next = decision_reg + DEC_W'({x_inc, 1'b0}) + DEC_W'(1);
                end
                else
                begin
                    off_y_next    = y_dec;
                    decision_next = decision_reg
                                  + ((DEC_W'(x_inc) - DEC_W'(y_dec)) << 1)
                                  + DEC_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        push_job.cx   = PIX_W'(ctr_x_next);
        push_job.cy   = PIX_W'(ctr_y_next);
        push_job.x    = off_x_next;
        push_job.y    = off_y_next;
        push_job.left = use_left_next;
        push_job.done = off_x_next >= off_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg    <= '0;
            ctr_y_reg    <= '0;
            use_left_reg <= 1'b0;
            off_x_reg    <= '0;
            off_y_reg    <= '0;
            decision_reg <= '0;
        end
        else
        begin
            ctr_x_reg    <= ctr_x_next;
            ctr_y_reg    <= ctr_y_next;
            use_left_reg <= use_left_next;
            off_x_reg    <= off_x_next;
            off_y_reg    <= off_y_next;
            decision_reg <= decision_next;
        end
    end

endmodule

FILE: rtl/msr_fifo.sv
`include "midpoint_semicircle_rasterizer_top_assert.svh"

module msr_fifo
    import msr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // Advance a pointer with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MSR_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `MSR_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop)
    `MSR_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, head_valid)
    `MSR_ASSERT_NEXT(a_push_only_grows, clk, rst_n, push && !pop, count_reg != '0)

endmodule

FILE: rtl/msr_back.sv
module msr_back
    import msr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  job_t      head,
    output logic      pop,
    msr_pix_if.source pix
);

    logic [PH_W-1:0]  phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] pixel_x_reg, pixel_x_next;
    logic [PIX_W-1:0] pixel_y_reg, pixel_y_next;
    logic             last_reg, last_next;
    logic             arc_done_reg, arc_done_next;

    logic             advance;
    logic [OFF_W-1:0] off_a;
    logic [OFF_W-1:0] off_b;

    assign advance = head_valid && (!out_valid_reg || pix.ready);
    assign pop     = advance && (phase_reg == PH_LAST);

    // Odd phases swap the roles of x and y; upper phases mirror below center.
    assign off_a = phase_reg[0] ? head.y : head.x;
    assign off_b = phase_reg[0] ? head.x : head.y;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        pixel_x_next   = pixel_x_reg;
        pixel_y_next   = pixel_y_reg;
        last_next      = last_reg;
        arc_done_next  = arc_done_reg;
        if (advance)
        begin
            phase_next     = phase_reg + PH_W'(1);
            out_valid_next = 1'b1;
            pixel_x_next   = head.left ? head.cx - PIX_W'(off_a) : head.cx + PIX_W'(off_a);
            pixel_y_next   = phase_reg[1] ? head.cy - PIX_W'(off_b) : head.cy + PIX_W'(off_b);
            last_next      = phase_reg == PH_LAST;
            arc_done_next  = head.done;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg  <= pixel_x_next;
        pixel_y_reg  <= pixel_y_next;
        last_reg     <= last_next;
        arc_done_reg <= arc_done_next;
    end

    assign pix.valid    = out_valid_reg;
    assign pix.pixel_x  = pixel_x_reg;
    assign pix.pixel_y  = pixel_y_reg;
    assign pix.last     = last_reg;
    assign pix.arc_done = arc_done_reg;

endmodule

FILE: rtl/midpoint_semicircle_rasterizer_top.sv
// The first pixel of a request passes through the queue entry and then the output register.
// Each drawing request yields four pixels, one per cycle on the output register unless stalled.
// A step on a finished arc is accepted but emits nothing; the 2-entry queue absorbs bursts.
// Reset (rst_n low, asynchronous): arc state cleared to zero, queue emptied,
// output valid dropped; the first request is taken in the cycle after release.
module midpoint_semicircle_rasterizer_top
    import msr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    msr_cmd_if.sink   cmd,
    msr_pix_if.source pix
);

    // Front end: take each request, advance the midpoint decision and the
    // x/y offsets right away, and push one arc position per drawing request.
    // A step request on a finished arc updates nothing and pushes nothing.
    logic push;
    job_t push_job;
    logic q_full;

    // Queue: hold arc positions so the front keeps accepting while the
    // pixel sequencer works through the four mirror points of earlier ones.
    logic head_valid;
    job_t head;
    logic pop;

    msr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    msr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: walk the four symmetric points of the queue head, one per cycle
    // into the output register unless the output stalls; pop the head as the fourth is loaded.
    msr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pix        (pix)
    );

endmodule
